// ===== src/mrf_pkg.sv =====
// mrf_pkg: shared types, constants and the crc byte step of the read request framer
// no dependencies
package mrf_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned FrameLen  = 8;
  localparam int unsigned CrcSpan   = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic [WordW-1:0] CrcInit = 16'hFFFF;
  localparam logic [WordW-1:0] CrcPoly = 16'hA001;

  localparam logic [ByteW-1:0] SlaveAddrRst   = 8'd1;
  localparam logic [ByteW-1:0] RequestCodeRst = 8'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSlaveAddr   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRequestCode = 2'd1;

  // one queued request with its header bytes attached
  typedef struct packed {
    logic [ByteW-1:0] slave_address;
    logic [ByteW-1:0] request_code;
    logic [WordW-1:0] start_register;
    logic [WordW-1:0] register_total;
  } req_t;

  // crc-16 modbus, one byte folded in, bit by bit lsb first
  function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] crc,
                                                 input logic [ByteW-1:0] data);
    logic [WordW-1:0] acc;
    acc = crc ^ {{(WordW-ByteW){1'b0}}, data};
    for (int b = 0; b < ByteW; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

// ===== src/mrf_if.sv =====
// mrf_req_if / mrf_frame_if: valid-ready channels of the read request framer
// depends on mrf_pkg
interface mrf_req_if;
  logic                          valid;
  logic                          ready;
  logic [mrf_pkg::WordW-1:0]     start_register;
  logic [mrf_pkg::WordW-1:0]     register_total;

  modport source (output valid, output start_register, output register_total, input ready);
  modport sink   (input valid, input start_register, input register_total, output ready);
endinterface

interface mrf_frame_if;
  logic                          valid;
  logic                          ready;
  logic [mrf_pkg::ByteW-1:0]     frame_byte;
  logic                          frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ===== src/mrf_front.sv =====
// mrf_front: configuration registers, request intake and header attach
// depends on mrf_pkg, mrf_if
module mrf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mrf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mrf_pkg::ByteW-1:0]    cfg_wdata_i,
  mrf_req_if.sink                      req_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output mrf_pkg::req_t                q_data_o
);
  import mrf_pkg::*;

  logic [ByteW-1:0] slave_addr_q, slave_addr_d;
  logic [ByteW-1:0] req_code_q, req_code_d;

  always_comb begin
    slave_addr_d = slave_addr_q;
    req_code_d   = req_code_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == RegSlaveAddr) begin
        slave_addr_d = cfg_wdata_i;
      end else if (cfg_idx_i == RegRequestCode) begin
        req_code_d = cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SlaveAddrRst;
      req_code_q   <= RequestCodeRst;
    end else begin
      slave_addr_q <= slave_addr_d;
      req_code_q   <= req_code_d;
    end
  end

  assign req_i.ready = !q_full_i;
  assign q_push_o    = req_i.valid && !q_full_i;

  always_comb begin
    q_data_o.slave_address  = slave_addr_q;
    q_data_o.request_code   = req_code_q;
    q_data_o.start_register = req_i.start_register;
    q_data_o.register_total = req_i.register_total;
  end

endmodule

// ===== src/mrf_queue.sv =====
// mrf_queue: small register queue between intake and frame sequencer
// depends on mrf_pkg
module mrf_queue #(
  parameter int unsigned Depth = mrf_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mrf_pkg::req_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mrf_pkg::req_t pop_data_o
);
  import mrf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  req_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/mrf_back.sv =====
// mrf_back: byte sequencer with running crc and output register
// depends on mrf_pkg, mrf_if
module mrf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  mrf_pkg::req_t q_data_i,
  output logic          q_pop_o,
  mrf_frame_if.source   frame_o
);
  import mrf_pkg::*;

  localparam int unsigned IdxW = $clog2(FrameLen);

  req_t             item_q;
  logic             busy_q;
  logic [IdxW-1:0]  idx_q;
  logic [WordW-1:0] crc_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_end_q;

  logic             out_free;
  logic             emit;
  logic             last;
  logic             load;
  logic [ByteW-1:0] cur_byte;

  always_comb begin
    unique case (idx_q)
      3'd0:    cur_byte = item_q.slave_address;
      3'd1:    cur_byte = item_q.request_code;
      3'd2:    cur_byte = item_q.start_register[WordW-1:ByteW];
      3'd3:    cur_byte = item_q.start_register[ByteW-1:0];
      3'd4:    cur_byte = item_q.register_total[WordW-1:ByteW];
      3'd5:    cur_byte = item_q.register_total[ByteW-1:0];
      3'd6:    cur_byte = crc_q[ByteW-1:0];
      default: cur_byte = crc_q[WordW-1:ByteW];
    endcase
  end

  assign out_free = !out_valid_q || frame_o.ready;
  assign emit     = busy_q && out_free;
  assign last     = (idx_q == IdxW'(FrameLen - 1));
  // next request is taken the cycle the last byte leaves, so frames run back to back
  assign load     = q_valid_i && (!busy_q || (emit && last));
  assign q_pop_o  = load;

  assign frame_o.valid      = out_valid_q;
  assign frame_o.frame_byte = out_byte_q;
  assign frame_o.frame_end  = out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= emit;
      end
      if (load) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (emit) begin
        if (last) begin
          busy_q <= 1'b0;
        end
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= q_data_i;
      crc_q  <= CrcInit;
    end else if (emit && (idx_q < IdxW'(CrcSpan))) begin
      crc_q <= crc_byte(crc_q, cur_byte);
    end
    if (emit) begin
      out_byte_q <= cur_byte;
      out_end_q  <= last;
    end
  end

endmodule

// ===== src/modbus_read_request_framer.sv =====
// modbus_read_request_framer: top level, read request in, 8-byte rtu request frame out
// depends on mrf_pkg, mrf_if, mrf_front, mrf_queue, mrf_back
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+-----------------------------------
//  req_i     | in  | valid / ready       | start_register[15:0], register_total[15:0]
//  frame_o   | out | valid / ready       | frame_byte[7:0], frame_end
//  cfg       | in  | cfg_we_i, no stall  | cfg_idx_i[1:0], cfg_wdata_i[7:0]
//
// each request yields eight byte transactions, one per cycle while frame_o is ready;
// the output byte sequencer takes the next request as the last byte of a frame goes out
// after the request transaction the first byte passes the queue, the sequencer item register, then the output register
// the crc is folded in one byte per cycle while frame_o is ready as header bytes go out, ready for bytes 6 and 7
// reset clears the queue, the sequencer and the output valid; config returns to 1 and 3
// a stall on frame_o holds the byte in place; requests keep entering until the queue fills
module modbus_read_request_framer #(
  parameter int unsigned QDepth = mrf_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mrf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mrf_pkg::ByteW-1:0]   cfg_wdata_i,
  mrf_req_if.sink                     req_i,
  mrf_frame_if.source                 frame_o
);
  import mrf_pkg::*;

  // front to queue
  logic q_push;
  logic q_full;
  req_t q_wdata;

  // queue to back
  logic q_pop;
  logic q_valid;
  req_t q_rdata;

  // intake: holds device address and function code, attaches them to each request
  mrf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  // decouples intake from the byte sequencer
  mrf_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  // walks the eight frame bytes, crc low then high byte last
  mrf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .frame_o   (frame_o)
  );

endmodule
